### hdl/ascii_sensor_frame_parser_top_macros.svh
// Assertion helpers shared by the frame parser modules.
`ifndef ASCII_SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define ASCII_SENSOR_FRAME_PARSER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/asfp_pkg.sv
package asfp_pkg;

  localparam logic [7:0]  CHAR_CR            = 8'h0d;
  localparam logic [7:0]  CHAR_COMMA         = 8'h2c;
  localparam logic [4:0]  COUNT_MAX          = 5'd31;
  localparam logic [2:0]  FIELD_NONE         = 3'd4;
  localparam logic [2:0]  FIELD_OVERFLOW     = 3'd7;
  localparam logic [2:0]  POS_MAX            = 3'd4;
  localparam logic [4:0]  FRAME_LENGTH_RESET = 5'd20;
  localparam logic [11:0] AC_OFFSET_RESET    = 12'd2048;

  localparam logic REG_FRAME_LENGTH = 1'b0;
  localparam logic REG_AC_OFFSET    = 1'b1;

  typedef logic [14:0] sum_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] ac_red;
    logic        [14:0] dc_red;
    logic signed [15:0] ac_infrared;
    logic        [14:0] dc_infrared;
  } result_t;

  function automatic logic [13:0] digit_term(input logic [3:0] nib, input logic [2:0] pos);
    logic [13:0] term;
    unique case (pos)
      3'd0:    term = 14'(nib) * 14'd1000;
      3'd1:    term = 14'(nib) * 14'd100;
      3'd2:    term = 14'(nib) * 14'd10;
      3'd3:    term = 14'(nib);
      default: term = 14'd0;
    endcase
    return term;
  endfunction

endpackage

### hdl/ascii_sensor_frame_parser_top.sv
// ASCII sensor frame parser. Takes one byte per beat on the in channel and
// sustains one byte per clock cycle while the out channel is not stalled.
// A byte passes an input register, then the frame state update and a
// result register; a frame's result is registered as its carriage-return
// byte leaves the input register. A stalled result holds any byte in the
// input register. Frames that do not have exactly frame_length bytes before
// the carriage return, or that overflow 31 bytes, give no result. Write the
// configuration registers only while the parser is idle.
`include "ascii_sensor_frame_parser_top_macros.svh"

module ascii_sensor_frame_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] ac_red,
  output logic        [14:0] dc_red,
  output logic signed [15:0] ac_infrared,
  output logic        [14:0] dc_infrared,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data
);
  import asfp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [4:0] frame_length;
  logic [11:0] ac_offset;
  logic       advance;
  logic       step;
  result_t    result;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_LENGTH_RESET;
      ac_offset    <= AC_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_LENGTH: frame_length <= cfg_data[4:0];
        REG_AC_OFFSET:    ac_offset    <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
  end

  asfp_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (s1_byte),
    .frame_length (frame_length),
    .ac_offset    (ac_offset),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      ac_red      <= result.ac_red;
      dc_red      <= result.dc_red;
      ac_infrared <= result.ac_infrared;
      dc_infrared <= result.dc_infrared;
    end
  end

  `ASFP_ASSERT(a_out_from_cr, $rose(out_valid) |-> $past(s1_valid && s1_byte == CHAR_CR), "result without carriage return")
  `ASFP_ASSERT(a_s1_hold, (s1_valid && !advance) |=> s1_valid, "input register dropped a stalled beat")
  `ASFP_ASSERT(a_out_hold, out_valid && !out_ready |=> $stable(ac_red), "stalled beat changed")

endmodule

### hdl/asfp_frame.sv
`include "ascii_sensor_frame_parser_top_macros.svh"

module asfp_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [4:0]           frame_length,
  input  logic [11:0]          ac_offset,
  output asfp_pkg::result_t    result
);
  import asfp_pkg::*;

  logic [4:0] byte_count, byte_count_next;
  logic [2:0] field_index, field_index_next;
  logic [2:0] digit_position, digit_position_next;
  sum_t       field_sums [4];
  sum_t       field_sums_next [4];
  logic [13:0] term;

  assign term = digit_term(rx_byte[3:0], digit_position);

  always_comb begin
    byte_count_next     = byte_count;
    field_index_next    = field_index;
    digit_position_next = digit_position;
    field_sums_next     = field_sums;
    result.valid        = 1'b0;
    result.ac_red       = 16'({1'b0, field_sums[0]}) - 16'({4'd0, ac_offset});
    result.dc_red       = field_sums[1];
    result.ac_infrared  = 16'({1'b0, field_sums[2]}) - 16'({4'd0, ac_offset});
    result.dc_infrared  = field_sums[3];
    if (step) begin
      if (rx_byte == CHAR_CR) begin
        result.valid        = (field_index != FIELD_OVERFLOW) && (byte_count == frame_length);
        byte_count_next     = '0;
        field_index_next    = '0;
        digit_position_next = '0;
        for (int i = 0; i < 4; i++) field_sums_next[i] = '0;
      end else if (byte_count == COUNT_MAX) begin
        field_index_next = FIELD_OVERFLOW;
      end else begin
        byte_count_next = byte_count + 5'd1;
        if (field_index != FIELD_OVERFLOW) begin
          if (rx_byte == CHAR_COMMA) begin
            if (field_index < FIELD_NONE) field_index_next = field_index + 3'd1;
            digit_position_next = '0;
          end else begin
            if (field_index < FIELD_NONE) begin
              field_sums_next[field_index[1:0]] =
                15'(field_sums[field_index[1:0]] + {1'b0, term});
            end
            if (digit_position < POS_MAX) digit_position_next = digit_position + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      field_index    <= '0;
      digit_position <= '0;
      for (int i = 0; i < 4; i++) field_sums[i] <= '0;
    end else begin
      byte_count     <= byte_count_next;
      field_index    <= field_index_next;
      digit_position <= digit_position_next;
      field_sums     <= field_sums_next;
    end
  end

  `ASFP_ASSERT_IMPL(a_overflow_full, field_index == FIELD_OVERFLOW, byte_count == COUNT_MAX, "overflow marked before count saturated")
  `ASFP_ASSERT(a_pos_bound, digit_position <= POS_MAX, "digit position past saturation")
  `ASFP_ASSERT(a_field_code, field_index <= FIELD_NONE || field_index == FIELD_OVERFLOW, "bad field index")

endmodule

### tb/tb_ascii_sensor_frame_parser_top.sv
`timescale 1ns / 100ps

module tb_ascii_sensor_frame_parser_top;
  import asfp_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int PHASE_ITEMS  = 160;
  localparam int PIPE_FLUSH   = 8;
  localparam int QUIET_LIMIT  = 500;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic signed [15:0] ac_red;
    logic        [14:0] dc_red;
    logic signed [15:0] ac_infrared;
    logic        [14:0] dc_infrared;
  } sensor_reading_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_VALUE, CHK_NONE} check_e;

  typedef struct {
    logic [4:0]      flen;
    logic [11:0]     offs;
    string           body;
    check_e          chk;
    sensor_reading_t want;
  } frame_case_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] ac_red;
  logic        [14:0] dc_red;
  logic signed [15:0] ac_infrared;
  logic        [14:0] dc_infrared;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_FRAME_LENGTH;
  logic [11:0]        cfg_data = 12'h000;

  // frame parser mirror
  logic [4:0]  cur_frame_len = FRAME_LENGTH_RESET;
  logic [11:0] cur_ac_offset = AC_OFFSET_RESET;
  logic [4:0]  byte_cnt = '0;
  logic [2:0]  field_idx = '0;
  logic [2:0]  digit_pos = '0;
  logic [14:0] field_sum [4] = '{default: '0};

  sensor_reading_t pending_readings[$];
  frame_case_t     frame_cases[$];
  int              items_sent = 0;
  int              error_count = 0;
  int              burst_left = 0;
  bit              gaps_on = 1'b1;
  int              quiet_cycles = 0;
  logic [9:0]      stall_tick = '0;

  ascii_sensor_frame_parser_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ac_red(ac_red),
    .dc_red(dc_red),
    .ac_infrared(ac_infrared),
    .dc_infrared(dc_infrared),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit parse_byte(input logic [7:0] b, output sensor_reading_t r);
    int  w;
    int  acc;
    bit  hit;
    hit = 1'b0;
    r = '0;
    if (b == CHAR_CR) begin
      hit = (field_idx != FIELD_OVERFLOW) && (byte_cnt == cur_frame_len);
      r.ac_red      = 16'(int'(field_sum[0]) - int'(cur_ac_offset));
      r.dc_red      = field_sum[1];
      r.ac_infrared = 16'(int'(field_sum[2]) - int'(cur_ac_offset));
      r.dc_infrared = field_sum[3];
      byte_cnt  = '0;
      field_idx = '0;
      digit_pos = '0;
      field_sum = '{default: '0};
    end else if (byte_cnt == COUNT_MAX) begin
      field_idx = FIELD_OVERFLOW;
    end else begin
      byte_cnt++;
      if (field_idx != FIELD_OVERFLOW) begin
        if (b == CHAR_COMMA) begin
          if (field_idx < FIELD_NONE) field_idx++;
          digit_pos = '0;
        end else begin
          if (field_idx < FIELD_NONE) begin
            case (digit_pos)
              3'd0:    w = 1000;
              3'd1:    w = 100;
              3'd2:    w = 10;
              3'd3:    w = 1;
              default: w = 0;
            endcase
            acc = int'(field_sum[field_idx[1:0]]) + int'(b[3:0]) * w;
            field_sum[field_idx[1:0]] = acc[14:0];
          end
          if (digit_pos < POS_MAX) digit_pos++;
        end
      end
    end
    return hit;
  endfunction

  function automatic void add_case(input int flen, input int offs, input string body,
                                   input check_e chk, input int ar = 0, input int dr = 0,
                                   input int ai = 0, input int di = 0);
    frame_case_t fc;
    fc.flen = 5'(flen);
    fc.offs = 12'(offs);
    fc.body = body;
    fc.chk  = chk;
    fc.want.ac_red      = 16'(ar);
    fc.want.dc_red      = 15'(dr);
    fc.want.ac_infrared = 16'(ai);
    fc.want.dc_infrared = 15'(di);
    frame_cases.push_back(fc);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // hold the beat until it is taken, then update the mirror
  task automatic send_byte(input logic [7:0] b, input check_e chk, input sensor_reading_t want);
    sensor_reading_t got;
    bit              hit;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    hit = parse_byte(b, got);
    case (chk)
      CHK_MODEL: if (hit) pending_readings.push_back(got);
      CHK_VALUE: pending_readings.push_back(want);
      default: ;
    endcase
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
      gaps_on = ($urandom_range(0, 7) != 0);
    end
    burst_left--;
  endtask

  // drain the pipe before touching the registers
  task automatic settle_and_configure(input logic [4:0] flen, input logic [11:0] offs);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_LENGTH;
    cfg_data  <= 12'(flen);
    @(posedge clk);
    cfg_index <= REG_AC_OFFSET;
    cfg_data  <= offs;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_frame_len = flen;
    cur_ac_offset = offs;
  endtask

  task automatic send_random_frame();
    int         n;
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 78) n = int'(cur_frame_len);
    else if (r < 88) n = $urandom_range(29, 36);
    else n = $urandom_range(0, 31);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) b = 8'($urandom_range(0, 255));
      else if (r < 22) b = CHAR_COMMA;
      else b = CHAR_ZERO + 8'($urandom_range(0, 9));
      pace();
      send_byte(b, CHK_MODEL, '0);
    end
    pace();
    send_byte(CHAR_CR, CHK_MODEL, '0);
  endtask

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 0);
      2'd2:    out_ready <= (stall_tick[2:0] == 3'd0);
      default: out_ready <= (stall_tick[4:3] != 2'd3);
    endcase
  end

  always @(posedge clk) begin
    sensor_reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("result with none pending, ac_red %0d", ac_red));
      end else begin
        want = pending_readings.pop_front();
        if (ac_red !== want.ac_red)
          report_mismatch($sformatf("ac_red %0d, expected %0d", ac_red, want.ac_red));
        if (dc_red !== want.dc_red)
          report_mismatch($sformatf("dc_red %0d, expected %0d", dc_red, want.dc_red));
        if (ac_infrared !== want.ac_infrared)
          report_mismatch($sformatf("ac_infrared %0d, expected %0d",
                                    ac_infrared, want.ac_infrared));
        if (dc_infrared !== want.dc_infrared)
          report_mismatch($sformatf("dc_infrared %0d, expected %0d",
                                    dc_infrared, want.dc_infrared));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[ascii_sensor_frame_parser_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    frame_case_t fc;
    int          ph;
    int          phase_end;
    int          rand_start;

    add_case(20, 2048, "2048,0100,4095,9999,", CHK_VALUE, 0, 100, 2047, 9999);
    add_case(20, 2048, "1111,2222,3333,4444", CHK_NONE);
    add_case(20, 2048, "1111,2222,3333,44445", CHK_VALUE, -937, 2222, 1285, 4444);
    add_case(20, 2048, "AB;D,zy@,~!#,{}|?Q", CHK_MODEL);
    add_case(1, 0, "5", CHK_VALUE, 5000, 0, 0, 0);
    add_case(1, 0, ",", CHK_VALUE, 0, 0, 0, 0);
    add_case(1, 0, "", CHK_NONE);
    add_case(0, 0, "", CHK_VALUE, 0, 0, 0, 0);
    add_case(0, 4095, "", CHK_VALUE, -4095, 0, -4095, 0);
    add_case(5, 4095, ",,,,,", CHK_VALUE, -4095, 0, -4095, 0);
    add_case(19, 0, "????,????,????,????", CHK_VALUE, 16665, 16665, 16665, 16665);
    add_case(31, 4095, "9999,9999,9999,9999,,,,,,,,,,,,", CHK_VALUE, 5904, 9999, 5904, 9999);
    add_case(31, 4095, "9999,9999,9999,9999,,,,,,,,,,,,,", CHK_NONE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (frame_cases[k]) begin
      fc = frame_cases[k];
      if (fc.flen != cur_frame_len || fc.offs != cur_ac_offset)
        settle_and_configure(fc.flen, fc.offs);
      for (int i = 0; i < fc.body.len(); i++) begin
        pace();
        send_byte(fc.body[i], CHK_MODEL, '0);
      end
      pace();
      send_byte(CHAR_CR, fc.chk, fc.want);
    end

    rand_start = items_sent;
    ph = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      case (ph)
        0:       settle_and_configure(5'd31, 12'd0);
        1:       settle_and_configure(5'd1, 12'd4095);
        2:       settle_and_configure(5'd0, 12'($urandom_range(0, 4095)));
        3:       settle_and_configure(FRAME_LENGTH_RESET, AC_OFFSET_RESET);
        default: settle_and_configure(5'($urandom_range(1, 31)), 12'($urandom_range(0, 4095)));
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_frame();
      ph++;
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
    if (error_count == 0) begin
      $display("[ascii_sensor_frame_parser_top] OK");
    end else begin
      $display("[ascii_sensor_frame_parser_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/asfp_pkg.sv
hdl/asfp_frame.sv
hdl/ascii_sensor_frame_parser_top.sv
tb/tb_ascii_sensor_frame_parser_top.sv
